// ===== sv/cppa_pkg.sv =====
// ----------------------------------------------------------------------------
// cppa_pkg
// Types, codes and helper functions of the color pair palette allocator.
// ----------------------------------------------------------------------------
package cppa_pkg;

	localparam int CH_W   = 10;
	localparam int RAW_W  = 12;
	localparam int KEY_W  = 3 * CH_W;
	localparam int IDX_OUT_W = 9;
	localparam int CIDX_OUT_W = 8;
	localparam logic [CH_W-1:0] CH_MAX = 10'd1000;
	localparam logic [2:0] LAST_PRIMARY = 3'd7;

	localparam logic OP_COLOR = 1'b0;
	localparam logic OP_PAIR  = 1'b1;

	typedef enum logic [1:0] {
		KIND_COLOR  = 2'd0,
		KIND_PAIR   = 2'd1,
		KIND_ANSWER = 2'd2
	} kind_t;

	typedef struct packed {
		logic                    operation;
		logic signed [RAW_W-1:0] front_red;
		logic signed [RAW_W-1:0] front_green;
		logic signed [RAW_W-1:0] front_blue;
		logic signed [RAW_W-1:0] back_red;
		logic signed [RAW_W-1:0] back_green;
		logic signed [RAW_W-1:0] back_blue;
	} req_t;

	typedef struct packed {
		kind_t                 kind;
		logic [IDX_OUT_W-1:0]  index;
		logic [CH_W-1:0]       red;
		logic [CH_W-1:0]       green;
		logic [CH_W-1:0]       blue;
		logic [CIDX_OUT_W-1:0] front_index;
		logic [CIDX_OUT_W-1:0] back_index;
		logic                  full_res;
		logic                  last;
	} rsp_t;

	function automatic logic [CH_W-1:0] clamp_ch(input logic signed [RAW_W-1:0] v);
		logic [CH_W-1:0] r;
		if (v[RAW_W-1]) begin
			r = '0;
		end else if (v > $signed({2'b00, CH_MAX})) begin
			r = CH_MAX;
		end else begin
			r = v[CH_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] color_key(input logic signed [RAW_W-1:0] r,
			input logic signed [RAW_W-1:0] g, input logic signed [RAW_W-1:0] b);
		return {clamp_ch(b), clamp_ch(g), clamp_ch(r)};
	endfunction

	function automatic logic [KEY_W-1:0] primary_key(input logic [2:0] p);
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		r = p[2] ? CH_MAX : '0;
		g = p[1] ? CH_MAX : '0;
		b = p[0] ? CH_MAX : '0;
		return {b, g, r};
	endfunction

endpackage

// ===== sv/color_pair_palette_allocator.sv =====
// ----------------------------------------------------------------------------
// color_pair_palette_allocator
// Interns colors and front/back color pairs into two bounded tables.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, payload req): one request per
//   transaction, either a single color or a front/back pair.
//   rsp channel (rsp_valid/rsp_ready, payload rsp): zero or more color and
//   pair definitions, then one answer with last set.
//   Each table lookup scans the stored entries through one read port, one
//   entry per cycle with one shared comparator. A single color request
//   makes one color lookup; a pair request makes two color lookups and,
//   if both colors are stored, one pair lookup, plus 8 color lookups of the
//   primaries while the pair table is still empty.
//   req_ready is high only between requests; the final answer may still wait
//   in the output register while the next request is taken.
//   A stalled receiver holds the sequencer at its next result.
//   Reset empties both tables through their counts; no clearing pass runs.
// ----------------------------------------------------------------------------
module color_pair_palette_allocator #(
	parameter int COLOR_ENTRIES = 256,
	parameter int PAIR_ENTRIES  = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cppa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cppa_pkg::rsp_t rsp
);

	localparam int CIW   = $clog2(COLOR_ENTRIES);
	localparam int PIW   = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
	localparam int CCW   = $clog2(COLOR_ENTRIES + 1);
	localparam int PCW   = $clog2(PAIR_ENTRIES + 1);
	localparam int CNT_W = (CCW > PCW) ? CCW : PCW;
	localparam int IDX_W = (CIW > PIW) ? CIW : PIW;
	localparam int PKW   = 2 * CIW;
	localparam int KEY_W = cppa_pkg::KEY_W;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CSCAN = 7'b0000010,
		ST_CDEF  = 7'b0000100,
		ST_CNEXT = 7'b0001000,
		ST_PSCAN = 7'b0010000,
		ST_PDEF  = 7'b0100000,
		ST_ANS   = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		PH_PRE   = 3'b001,
		PH_FRONT = 3'b010,
		PH_BACK  = 3'b100
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [2:0] p_q;
	logic [CCW-1:0] color_count_q;
	logic [PCW-1:0] pair_count_q;
	logic [CNT_W-1:0] issue_q;
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic rsp_valid_q;
	cppa_pkg::rsp_t rsp_q;

	logic op_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] front_key_q;
	logic [KEY_W-1:0] back_key_q;
	logic [CIW-1:0] fidx_q;
	logic [CIW-1:0] bidx_q;
	logic [CIW-1:0] cur_idx_q;
	logic fok_q;
	logic bok_q;
	logic [cppa_pkg::IDX_OUT_W-1:0] ans_idx_q;
	logic ans_full_q;

	logic [KEY_W-1:0] color_mem [COLOR_ENTRIES];
	logic [PKW-1:0] pair_mem [PAIR_ENTRIES];
	logic [KEY_W-1:0] crd_q;
	logic [PKW-1:0] prd_q;

	logic scan_c;
	logic scan_p;
	logic scanning;
	logic [CNT_W-1:0] lim;
	logic issue_go;
	logic [KEY_W-1:0] cmp_data;
	logic hit;
	logic miss;
	logic c_room;
	logic p_room;
	logic c_we;
	logic p_we;
	logic slot_free;
	logic [CIW-1:0] new_cidx;
	logic [CIW-1:0] hit_cidx;

	assign scan_c    = (state_q == ST_CSCAN);
	assign scan_p    = (state_q == ST_PSCAN);
	assign scanning  = scan_c || scan_p;
	assign lim       = scan_p ? CNT_W'(pair_count_q) : CNT_W'(color_count_q);
	assign issue_go  = scanning && (issue_q < lim);
	assign cmp_data  = scan_p ? KEY_W'(prd_q) : crd_q;
	assign hit       = scanning && vld_s1 && (cmp_data == key_q);
	assign miss      = scanning && !vld_s1 && !issue_go;
	assign c_room    = (color_count_q < CCW'(COLOR_ENTRIES));
	assign p_room    = (pair_count_q < PCW'(PAIR_ENTRIES));
	assign c_we      = scan_c && miss && c_room;
	assign p_we      = scan_p && miss && p_room;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign new_cidx  = color_count_q[CIW-1:0];
	assign hit_cidx  = idx_s1[CIW-1:0];

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (c_we) begin
			color_mem[new_cidx] <= key_q;
		end
		if (p_we) begin
			pair_mem[pair_count_q[PIW-1:0]] <= key_q[PKW-1:0];
		end
		crd_q <= color_mem[issue_q[CIW-1:0]];
		prd_q <= pair_mem[issue_q[PIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_FRONT;
			p_q           <= '0;
			color_count_q <= '0;
			pair_count_q  <= '0;
			issue_q       <= '0;
			vld_s1        <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (scanning && !hit && !miss) begin
				issue_q <= issue_q + CNT_W'(issue_go);
			end else begin
				issue_q <= '0;
			end
			vld_s1 <= issue_go && !hit && !miss;
			if (c_we) begin
				color_count_q <= color_count_q + 1'b1;
			end
			if (p_we) begin
				pair_count_q <= pair_count_q + 1'b1;
			end
			if ((state_q == ST_CDEF || state_q == ST_PDEF || state_q == ST_ANS) && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CSCAN;
						p_q     <= '0;
						if (req.operation == cppa_pkg::OP_PAIR && pair_count_q == '0) begin
							phase_q <= PH_PRE;
						end else begin
							phase_q <= PH_FRONT;
						end
					end
				end
				ST_CSCAN: begin
					if (hit) begin
						state_q <= ST_CNEXT;
					end else if (miss) begin
						state_q <= c_room ? ST_CDEF : ST_CNEXT;
					end
				end
				ST_CDEF: begin
					if (slot_free) begin
						state_q <= ST_CNEXT;
					end
				end
				ST_CNEXT: begin
					case (phase_q)
						PH_PRE: begin
							state_q <= ST_CSCAN;
							if (p_q == cppa_pkg::LAST_PRIMARY) begin
								phase_q <= PH_FRONT;
							end else begin
								p_q <= p_q + 3'd1;
							end
						end
						PH_FRONT: begin
							if (op_q == cppa_pkg::OP_COLOR) begin
								state_q <= ST_ANS;
							end else begin
								phase_q <= PH_BACK;
								state_q <= ST_CSCAN;
							end
						end
						PH_BACK: begin
							state_q <= (fok_q && bok_q) ? ST_PSCAN : ST_ANS;
						end
						default: begin
							state_q <= ST_ANS;
						end
					endcase
				end
				ST_PSCAN: begin
					if (hit) begin
						state_q <= ST_ANS;
					end else if (miss) begin
						state_q <= p_room ? ST_PDEF : ST_ANS;
					end
				end
				ST_PDEF: begin
					if (slot_free) begin
						state_q <= ST_ANS;
					end
				end
				ST_ANS: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				op_q        <= req.operation;
				front_key_q <= cppa_pkg::color_key(req.front_red, req.front_green, req.front_blue);
				back_key_q  <= cppa_pkg::color_key(req.back_red, req.back_green, req.back_blue);
				if (req.operation == cppa_pkg::OP_PAIR && pair_count_q == '0) begin
					key_q <= cppa_pkg::primary_key(3'd0);
				end else begin
					key_q <= cppa_pkg::color_key(req.front_red, req.front_green,
						req.front_blue);
				end
			end
			ST_CSCAN: begin
				if (hit) begin
					cur_idx_q <= hit_cidx;
					if (phase_q == PH_FRONT) begin
						fidx_q <= hit_cidx;
						fok_q  <= 1'b1;
					end
					if (phase_q == PH_BACK) begin
						bidx_q <= hit_cidx;
						bok_q  <= 1'b1;
					end
				end else if (miss) begin
					cur_idx_q <= new_cidx;
					if (phase_q == PH_FRONT) begin
						fidx_q <= new_cidx;
						fok_q  <= c_room;
					end
					if (phase_q == PH_BACK) begin
						bidx_q <= new_cidx;
						bok_q  <= c_room;
					end
				end
			end
			ST_CDEF: begin
				if (slot_free) begin
					rsp_q <= '{
						kind:        cppa_pkg::KIND_COLOR,
						index:       cppa_pkg::IDX_OUT_W'(cur_idx_q),
						red:         key_q[9:0],
						green:       key_q[19:10],
						blue:        key_q[29:20],
						front_index: '0,
						back_index:  '0,
						full_res:    1'b0,
						last:        1'b0
					};
				end
			end
			ST_CNEXT: begin
				case (phase_q)
					PH_PRE: begin
						if (p_q == cppa_pkg::LAST_PRIMARY) begin
							key_q <= front_key_q;
						end else begin
							key_q <= cppa_pkg::primary_key(p_q + 3'd1);
						end
					end
					PH_FRONT: begin
						key_q      <= back_key_q;
						ans_idx_q  <= fok_q ? cppa_pkg::IDX_OUT_W'(fidx_q) : '0;
						ans_full_q <= !fok_q;
					end
					PH_BACK: begin
						key_q      <= KEY_W'({bidx_q, fidx_q});
						ans_idx_q  <= '0;
						ans_full_q <= 1'b1;
					end
					default: begin
						ans_idx_q  <= '0;
						ans_full_q <= 1'b1;
					end
				endcase
			end
			ST_PSCAN: begin
				if (hit) begin
					ans_idx_q  <= cppa_pkg::IDX_OUT_W'(idx_s1) + 1'b1;
					ans_full_q <= 1'b0;
				end else if (miss) begin
					ans_idx_q  <= p_room ? cppa_pkg::IDX_OUT_W'(pair_count_q) + 1'b1 : '0;
					ans_full_q <= !p_room;
				end
			end
			ST_PDEF: begin
				if (slot_free) begin
					rsp_q <= '{
						kind:        cppa_pkg::KIND_PAIR,
						index:       ans_idx_q,
						red:         '0,
						green:       '0,
						blue:        '0,
						front_index: cppa_pkg::CIDX_OUT_W'(fidx_q),
						back_index:  cppa_pkg::CIDX_OUT_W'(bidx_q),
						full_res:    1'b0,
						last:        1'b0
					};
				end
			end
			ST_ANS: begin
				if (slot_free) begin
					rsp_q <= '{
						kind:        cppa_pkg::KIND_ANSWER,
						index:       ans_idx_q,
						red:         '0,
						green:       '0,
						blue:        '0,
						front_index: '0,
						back_index:  '0,
						full_res:    ans_full_q,
						last:        1'b1
					};
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_color_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		color_count_q <= CCW'(COLOR_ENTRIES))
		else $error("color count beyond table size");

	a_pair_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> pair_count_q >= $past(pair_count_q))
		else $error("pair count decreased");

	a_last_on_answer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind == cppa_pkg::KIND_ANSWER)))
		else $error("last does not match answer kind");

	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.full_res |-> rsp.index == '0)
		else $error("full answer with nonzero index");

	a_pair_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		p_we |-> fok_q && bok_q)
		else $error("pair stored with a missing color");
`endif

endmodule

// ===== bench/color_pair_palette_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_pair_palette_allocator_tb
// Drives color and front/back pair requests through the palette allocator and
// checks every definition record and answer against an in-bench copy of both
// tables. The run fills the color table with single colors first, so that the
// primary preload meets a nearly full table, then sends pair requests and
// singles against the full color table. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module color_pair_palette_allocator_tb;

	localparam int COLOR_ENTRIES = 256;
	localparam int PAIR_ENTRIES  = 256;
	localparam int CHANNEL_TOP   = 1000;
	localparam int CH_W          = cppa_pkg::CH_W;
	localparam int RAW_W         = cppa_pkg::RAW_W;
	localparam int IDX_OUT_W     = cppa_pkg::IDX_OUT_W;
	localparam int CIDX_OUT_W    = cppa_pkg::CIDX_OUT_W;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	cppa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	cppa_pkg::rsp_t rsp;

	logic [2:0] req_gap = '0;
	logic [2:0] rsp_gap = '0;
	logic rsp_hold = 1'b0;
	int accepted_cnt = 0;
	int result_cnt = 0;
	int fault_cnt = 0;

	// in-bench copy of the block's tables
	shade_t palette[COLOR_ENTRIES];
	int palette_fill = 0;
	logic [15:0] duo_table[PAIR_ENTRIES];
	int duo_fill = 0;
	cppa_pkg::rsp_t due_records[$];

	// stimulus-side view of the color table
	cppa_pkg::req_t request_backlog[$];
	bit shade_seen[int];
	shade_t shade_list[$];

	color_pair_palette_allocator #(
		.COLOR_ENTRIES(COLOR_ENTRIES),
		.PAIR_ENTRIES(PAIR_ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	function automatic logic [CH_W-1:0] saturate(input logic signed [RAW_W-1:0] raw);
		if (raw < 0) return '0;
		if (raw > CHANNEL_TOP) return CH_W'(CHANNEL_TOP);
		return raw[CH_W-1:0];
	endfunction

	function automatic shade_t to_shade(input logic signed [RAW_W-1:0] r,
			input logic signed [RAW_W-1:0] g, input logic signed [RAW_W-1:0] b);
		shade_t s;
		s.r = saturate(r);
		s.g = saturate(g);
		s.b = saturate(b);
		return s;
	endfunction

	function automatic void post_record(input cppa_pkg::kind_t k, input int idx,
			input shade_t s, input int fi, input int bi, input bit full);
		cppa_pkg::rsp_t rec;
		rec = '0;
		rec.kind = k;
		rec.index = idx[IDX_OUT_W-1:0];
		rec.red = s.r;
		rec.green = s.g;
		rec.blue = s.b;
		rec.front_index = fi[CIDX_OUT_W-1:0];
		rec.back_index = bi[CIDX_OUT_W-1:0];
		rec.full_res = full;
		rec.last = (k == cppa_pkg::KIND_ANSWER);
		due_records.push_back(rec);
	endfunction

	function automatic bit intern_shade(input shade_t s, output int slot);
		slot = 0;
		for (int i = 0; i < palette_fill; i++) begin
			if (palette[i] == s) begin
				slot = i;
				return 1'b1;
			end
		end
		if (palette_fill >= COLOR_ENTRIES) return 1'b0;
		palette[palette_fill] = s;
		slot = palette_fill;
		palette_fill++;
		post_record(cppa_pkg::KIND_COLOR, slot, s, 0, 0, 1'b0);
		return 1'b1;
	endfunction

	function automatic void allocate_request(input cppa_pkg::req_t q);
		shade_t fs;
		shade_t bs;
		int fslot;
		int bslot;
		int scratch;
		bit fok;
		bit bok;
		logic [15:0] key;
		fs = to_shade(q.front_red, q.front_green, q.front_blue);
		if (q.operation == cppa_pkg::OP_COLOR) begin
			if (intern_shade(fs, fslot)) begin
				post_record(cppa_pkg::KIND_ANSWER, fslot, '0, 0, 0, 1'b0);
			end else begin
				post_record(cppa_pkg::KIND_ANSWER, 0, '0, 0, 0, 1'b1);
			end
			return;
		end
		if (duo_fill == 0) begin
			for (int p = 0; p < 8; p++) begin
				bs.r = p[2] ? CH_W'(CHANNEL_TOP) : '0;
				bs.g = p[1] ? CH_W'(CHANNEL_TOP) : '0;
				bs.b = p[0] ? CH_W'(CHANNEL_TOP) : '0;
				void'(intern_shade(bs, scratch));
			end
		end
		bs = to_shade(q.back_red, q.back_green, q.back_blue);
		fok = intern_shade(fs, fslot);
		bok = intern_shade(bs, bslot);
		if (!fok || !bok) begin
			post_record(cppa_pkg::KIND_ANSWER, 0, '0, 0, 0, 1'b1);
			return;
		end
		key = {fslot[7:0], bslot[7:0]};
		for (int i = 0; i < duo_fill; i++) begin
			if (duo_table[i] == key) begin
				post_record(cppa_pkg::KIND_ANSWER, i + 1, '0, 0, 0, 1'b0);
				return;
			end
		end
		if (duo_fill >= PAIR_ENTRIES) begin
			post_record(cppa_pkg::KIND_ANSWER, 0, '0, 0, 0, 1'b1);
			return;
		end
		duo_table[duo_fill] = key;
		duo_fill++;
		post_record(cppa_pkg::KIND_PAIR, duo_fill, '0, fslot, bslot, 1'b0);
		post_record(cppa_pkg::KIND_ANSWER, duo_fill, '0, 0, 0, 1'b0);
	endfunction

	function automatic string diff_fields(input cppa_pkg::rsp_t want,
			input cppa_pkg::rsp_t got);
		string s;
		s = "";
		if (got.kind !== want.kind)
			s = {s, $sformatf(" kind exp %0d got %0d", want.kind, got.kind)};
		if (got.index !== want.index)
			s = {s, $sformatf(" index exp %0d got %0d", want.index, got.index)};
		if (got.red !== want.red)
			s = {s, $sformatf(" red exp %0d got %0d", want.red, got.red)};
		if (got.green !== want.green)
			s = {s, $sformatf(" green exp %0d got %0d", want.green, got.green)};
		if (got.blue !== want.blue)
			s = {s, $sformatf(" blue exp %0d got %0d", want.blue, got.blue)};
		if (got.front_index !== want.front_index)
			s = {s, $sformatf(" front_index exp %0d got %0d", want.front_index,
				got.front_index)};
		if (got.back_index !== want.back_index)
			s = {s, $sformatf(" back_index exp %0d got %0d", want.back_index,
				got.back_index)};
		if (got.full_res !== want.full_res)
			s = {s, $sformatf(" full_res exp %0d got %0d", want.full_res, got.full_res)};
		if (got.last !== want.last)
			s = {s, $sformatf(" last exp %0d got %0d", want.last, got.last)};
		return s;
	endfunction

	function automatic void note_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 10) $display("mismatch: %s", msg);
	endfunction

	function automatic int idle_draw();
		if (accepted_cnt >= 150 && accepted_cnt < 200) return 0;
		return $urandom_range(0, 4);
	endfunction

	// random raw value that clamps to the given channel
	function automatic logic signed [RAW_W-1:0] raw_for(input logic [CH_W-1:0] ch);
		if (ch == 0) begin
			if ($urandom_range(0, 1) == 0) return '0;
			return RAW_W'(-int'($urandom_range(1, 2048)));
		end
		if (ch == CHANNEL_TOP) return RAW_W'($urandom_range(CHANNEL_TOP, 2047));
		return RAW_W'(ch);
	endfunction

	function automatic logic [CH_W-1:0] draw_channel();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return '0;
		if (pick == 1) return CH_W'(CHANNEL_TOP);
		return CH_W'($urandom_range(1, CHANNEL_TOP - 1));
	endfunction

	// color that is neither known nor a primary
	function automatic shade_t fresh_shade();
		shade_t s;
		do begin
			s.r = draw_channel();
			s.g = draw_channel();
			s.b = draw_channel();
		end while (shade_seen.exists(int'(s)) ||
			((s.r == 0 || s.r == CHANNEL_TOP) && (s.g == 0 || s.g == CHANNEL_TOP) &&
			(s.b == 0 || s.b == CHANNEL_TOP)));
		return s;
	endfunction

	function automatic void note_shade(input shade_t s);
		if (!shade_seen.exists(int'(s))) begin
			shade_seen[int'(s)] = 1'b1;
			shade_list.push_back(s);
		end
	endfunction

	function automatic void queue_request(input logic op, input int fr, input int fg,
			input int fb, input int br, input int bg, input int bb);
		cppa_pkg::req_t q;
		q.operation = op;
		q.front_red = RAW_W'(fr);
		q.front_green = RAW_W'(fg);
		q.front_blue = RAW_W'(fb);
		q.back_red = RAW_W'(br);
		q.back_green = RAW_W'(bg);
		q.back_blue = RAW_W'(bb);
		request_backlog.push_back(q);
	endfunction

	function automatic void queue_single_raw(input int r, input int g, input int b);
		queue_request(cppa_pkg::OP_COLOR, r, g, b, $urandom, $urandom, $urandom);
		note_shade(to_shade(RAW_W'(r), RAW_W'(g), RAW_W'(b)));
	endfunction

	function automatic void queue_single(input shade_t s);
		queue_request(cppa_pkg::OP_COLOR, raw_for(s.r), raw_for(s.g), raw_for(s.b),
			$urandom, $urandom, $urandom);
	endfunction

	function automatic void queue_pair(input shade_t f, input shade_t b);
		queue_request(cppa_pkg::OP_PAIR, raw_for(f.r), raw_for(f.g), raw_for(f.b),
			raw_for(b.r), raw_for(b.g), raw_for(b.b));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			req_gap <= '0;
		end else begin
			if (req_valid && req_ready) begin
				allocate_request(req);
				accepted_cnt++;
			end
			if (!req_valid || req_ready) begin
				if (req_gap != 0) begin
					req_gap <= req_gap - 1'b1;
					req_valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					req <= request_backlog.pop_front();
					req_valid <= 1'b1;
					req_gap <= 3'(idle_draw());
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_side
		int gap;
		cppa_pkg::rsp_t want;
		string diff;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap <= '0;
		end else begin
			gap = rsp_gap;
			if (rsp_valid && rsp_ready) begin
				result_cnt++;
				if (due_records.size() == 0) begin
					note_fault($sformatf("unexpected result %0d: %p", result_cnt, rsp));
				end else begin
					want = due_records.pop_front();
					diff = diff_fields(want, rsp);
					if (diff != "") note_fault($sformatf("result %0d:%s", result_cnt, diff));
				end
				gap = idle_draw();
			end else if (gap != 0) begin
				gap--;
			end
			rsp_gap <= 3'(gap);
			rsp_ready <= (gap == 0) && !rsp_hold;
		end
	end

	// long receiver hold-off while requests keep coming
	initial begin
		while (accepted_cnt < 40) @(posedge clk);
		rsp_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		shade_t a;
		shade_t b;
		shade_t c;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		queue_single_raw(2047, 1000, 1500);
		queue_single_raw(-2048, -1, 0);
		queue_single_raw(1001, 0, -7);
		queue_single_raw(0, 1999, -1);
		queue_single_raw(1000, 1000, 1000);
		queue_single_raw(999, 1, 500);
		queue_single_raw(-1024, 1024, 512);
		queue_single_raw(1, 2, 3);
		queue_single_raw(999, 1, 500);
		queue_single_raw(2047, 2047, 2047);
		queue_single_raw(1000, -2048, 1);

		// leave three slots for the preload
		while (shade_list.size() < COLOR_ENTRIES - 3) begin
			a = fresh_shade();
			note_shade(a);
			queue_single(a);
		end
		while (request_backlog.size() != 0 || req_valid || due_records.size() != 0)
			@(posedge clk);

		a = shade_list[8];
		b = shade_list[20];
		c = shade_list[2];
		queue_pair(fresh_shade(), a);
		queue_single(fresh_shade());
		queue_pair(b, fresh_shade());
		queue_pair(fresh_shade(), fresh_shade());
		queue_single(c);
		queue_pair(a, b);
		queue_pair(a, b);
		queue_pair(b, a);
		queue_pair(c, c);
		queue_single(shade_list[$urandom_range(100, COLOR_ENTRIES - 4)]);
		queue_single(shade_list[COLOR_ENTRIES - 4]);
		queue_pair(c, c);
		while (request_backlog.size() != 0 || req_valid || due_records.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (fault_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
